FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RPI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("port check failed");

// consequent must hold in the cycle after the antecedent
`define RPI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

FILE: rtl/rpi_pkg.sv
`default_nettype none

package rpi_pkg;

    localparam int RPI_FRAC_BITS = 16;

    localparam int COORD_W     = 32;
    localparam int OFFSET_W    = 48;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int DOT_W       = PROD_W + 2;
    localparam int DMAG_W      = PROD_W;
    localparam int QUO_W       = COORD_W + 1;
    localparam int CFG_INDEX_W = 4;
    localparam int IN_DATA_W   = 6 * COORD_W;

    localparam logic signed [COORD_W-1:0] NORMAL_Y_RESET = 32'sd65536;
    localparam logic [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] DIST_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z,
        REG_PLANE_OFFSET
    } cfg_reg_t;

    // side info that travels with each word through the divider
    typedef struct packed {
        logic miss;
        logic neg;
    } rpi_tag_t;

    // width of the numerator magnitude
    function automatic int mag_width(input int frac_bits);
        int shifted;
        shifted = OFFSET_W + frac_bits;
        return (shifted > DOT_W) ? shifted : DOT_W;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rpi_div.sv
`default_nettype none

module rpi_div #(
    parameter int FRAC_BITS = rpi_pkg::RPI_FRAC_BITS,
    localparam int MAG_W = rpi_pkg::mag_width(FRAC_BITS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  rpi_pkg::rpi_tag_t             in_tag,
    input  logic [MAG_W-1:0]              in_mag,
    input  logic [rpi_pkg::DMAG_W-1:0]    in_dmag,
    output logic                          out_valid,
    output rpi_pkg::rpi_tag_t             out_tag,
    output logic                          out_ovf,
    output logic [rpi_pkg::QUO_W-1:0]     out_quo
);
    import rpi_pkg::*;

    localparam int DVD_W = MAG_W + FRAC_BITS;
    localparam int HI_W  = DVD_W - QUO_W;
    localparam int CMP_W = (HI_W > DMAG_W) ? HI_W : DMAG_W;
    localparam int NSTG  = QUO_W + 1;

    logic [DVD_W-1:0]  dividend;
    logic [CMP_W-1:0]  hi_ext;
    logic              ovf_next;

    logic [NSTG-1:0]   vld_reg;
    logic [DMAG_W-1:0] rem_reg  [QUO_W];
    logic [DMAG_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0]  low_reg  [QUO_W];
    logic [QUO_W-1:0]  low_next [QUO_W];
    logic [DMAG_W-1:0] dmag_reg [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [NSTG];
    logic [QUO_W-1:0]  quo_next [NSTG];
    rpi_tag_t          tag_reg  [NSTG];
    logic              ovf_reg  [NSTG];
    logic [DMAG_W:0]   trial    [QUO_W];
    logic [DMAG_W:0]   diff     [QUO_W];

    always_comb begin
        // entry stage: overflow test and initial partial remainder
        dividend    = DVD_W'(in_mag) << FRAC_BITS;
        hi_ext      = CMP_W'(dividend[DVD_W-1:QUO_W]);
        ovf_next    = hi_ext >= CMP_W'(in_dmag);
        rem_next[0] = hi_ext[DMAG_W-1:0];
        low_next[0] = dividend[QUO_W-1:0];
        quo_next[0] = '0;
        // one restoring step per stage
        for (int k = 0; k < QUO_W; k++) begin
            trial[k]      = {rem_reg[k], low_reg[k][QUO_W-1]};
            diff[k]       = trial[k] - {1'b0, dmag_reg[k]};
            quo_next[k+1] = {quo_reg[k][QUO_W-2:0], ~diff[k][DMAG_W]};
        end
        for (int k = 0; k < QUO_W - 1; k++) begin
            rem_next[k+1] = diff[k][DMAG_W] ? trial[k][DMAG_W-1:0] : diff[k][DMAG_W-1:0];
            low_next[k+1] = low_reg[k] << 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= rem_next[0];
            low_reg[0]  <= low_next[0];
            dmag_reg[0] <= in_dmag;
            quo_reg[0]  <= quo_next[0];
            tag_reg[0]  <= in_tag;
            ovf_reg[0]  <= ovf_next;
            for (int k = 1; k < NSTG; k++) begin
                quo_reg[k] <= quo_next[k];
                tag_reg[k] <= tag_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
            for (int k = 1; k < QUO_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= low_next[k];
                dmag_reg[k] <= dmag_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_tag   = tag_reg[NSTG-1];
    assign out_ovf   = ovf_reg[NSTG-1];
    assign out_quo   = quo_reg[NSTG-1];

endmodule

`default_nettype wire

FILE: rtl/ray_plane_intersect.sv
`default_nettype none

// Ray/plane intersection in signed fixed point with FRAC_BITS fraction bits. Each word on the
// s_ side is one ray; each word on the m_ side is its result: tuser is the hit flag and tdata
// the ray parameter t, truncated toward zero, less one LSB, saturated to 32 bits, or -1.0 when
// the normal-direction dot product is below one LSB in magnitude. The pipeline takes one ray
// every cycle while the skid register is empty; it goes through four stages for the products,
// dot products, magnitudes and parallel test, then an entry stage and 33 restoring divider
// stages that each resolve one quotient bit, then the output register. A skid register behind
// the output keeps one result aside, so s_tready drops only once two results are waiting.
// The user must write the plane (normal and offset) through the cfg port only while no ray is
// in flight, not enforced by the block; writes to indexes past the plane offset are dropped.

module ray_plane_intersect #(
    parameter int FRAC_BITS = rpi_pkg::RPI_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rpi_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rpi_pkg::OFFSET_W-1:0]      cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [rpi_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // distance
    output logic [rpi_pkg::COORD_W-1:0]       m_tdata,
    // hit
    output logic                              m_tuser
);
    import rpi_pkg::*;

    localparam int MAG_W = mag_width(FRAC_BITS);
    localparam int NUM_W = MAG_W + 1;
    localparam logic [COORD_W-1:0] MISS_DIST = -(COORD_W'(1) << FRAC_BITS);
    localparam logic [QUO_W-1:0]   POS_LIMIT = QUO_W'(1) << (COORD_W - 1);

    logic signed [COORD_W-1:0]  normal_reg [3];
    logic signed [OFFSET_W-1:0] plane_offset_reg;

    logic adv;

    logic                      p1_valid_reg;
    logic signed [PROD_W-1:0]  prod_o_reg  [3];
    logic signed [PROD_W-1:0]  prod_d_reg  [3];
    logic signed [PROD_W-1:0]  prod_o_next [3];
    logic signed [PROD_W-1:0]  prod_d_next [3];

    logic                      p2_valid_reg;
    logic signed [DOT_W-1:0]   dot_o_reg, dot_o_next;
    logic signed [DOT_W-1:0]   dot_d_reg, dot_d_next;

    logic                      p3_valid_reg;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic [DOT_W-1:0]          den_abs;
    logic [DMAG_W-1:0]         dmag3_reg, dmag3_next;
    logic                      den_neg_reg, den_neg_next;

    logic                      p4_valid_reg;
    logic [NUM_W-1:0]          num_abs;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic [DMAG_W-1:0]         dmag4_reg;
    rpi_tag_t                  tag_reg, tag_next;

    logic                      div_valid;
    rpi_tag_t                  div_tag;
    logic                      div_ovf;
    logic [QUO_W-1:0]          div_quo;

    logic                      res_valid;
    logic                      res_hit;
    logic [COORD_W-1:0]        res_dist;

    logic                      out_load;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_hit_reg, out_hit_next;
    logic [COORD_W-1:0]        out_dist_reg, out_dist_next;
    logic                      skid_valid_reg, skid_valid_next;
    logic                      skid_hit_reg, skid_hit_next;
    logic [COORD_W-1:0]        skid_dist_reg, skid_dist_next;

    // plane registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normal_reg[0]    <= '0;
            normal_reg[1]    <= NORMAL_Y_RESET;
            normal_reg[2]    <= '0;
            plane_offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_NORMAL_X:     normal_reg[0]    <= cfg_data[COORD_W-1:0];
                REG_NORMAL_Y:     normal_reg[1]    <= cfg_data[COORD_W-1:0];
                REG_NORMAL_Z:     normal_reg[2]    <= cfg_data[COORD_W-1:0];
                REG_PLANE_OFFSET: plane_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stages and divider move unless the skid register is holding a result
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod_o_next[i] = normal_reg[i] * $signed(s_tdata[i*COORD_W +: COORD_W]);
            prod_d_next[i] = normal_reg[i] * $signed(s_tdata[(i+3)*COORD_W +: COORD_W]);
        end
    end

    always_comb begin
        dot_o_next = DOT_W'(prod_o_reg[0]) + DOT_W'(prod_o_reg[1]) + DOT_W'(prod_o_reg[2]);
        dot_d_next = DOT_W'(prod_d_reg[0]) + DOT_W'(prod_d_reg[1]) + DOT_W'(prod_d_reg[2]);
    end

    always_comb begin
        den_neg_next = dot_d_reg[DOT_W-1];
        den_abs      = den_neg_next ? -dot_d_reg : dot_d_reg;
        dmag3_next   = den_abs[DMAG_W-1:0];
        num_next     = (NUM_W'(plane_offset_reg) <<< FRAC_BITS) - NUM_W'(dot_o_reg);
    end

    always_comb begin
        num_abs       = num_reg[NUM_W-1] ? -num_reg : num_reg;
        mag_next      = num_abs[MAG_W-1:0];
        tag_next.miss = (dmag3_reg[DMAG_W-1:FRAC_BITS] == '0);
        tag_next.neg  = num_reg[NUM_W-1] ^ den_neg_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= s_tvalid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_o_reg  <= prod_o_next;
            prod_d_reg  <= prod_d_next;
            dot_o_reg   <= dot_o_next;
            dot_d_reg   <= dot_d_next;
            num_reg     <= num_next;
            dmag3_reg   <= dmag3_next;
            den_neg_reg <= den_neg_next;
            mag_reg     <= mag_next;
            dmag4_reg   <= dmag3_reg;
            tag_reg     <= tag_next;
        end
    end

    rpi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p4_valid_reg),
        .in_tag    (tag_reg),
        .in_mag    (mag_reg),
        .in_dmag   (dmag4_reg),
        .out_valid (div_valid),
        .out_tag   (div_tag),
        .out_ovf   (div_ovf),
        .out_quo   (div_quo)
    );

    // miss value, sign, minus one lsb and saturation
    always_comb begin
        res_valid = div_valid && adv;
        res_hit   = !div_tag.miss;
        if (div_tag.miss) begin
            res_dist = MISS_DIST;
        end else if (!div_tag.neg) begin
            if (div_ovf || div_quo > POS_LIMIT) begin
                res_dist = DIST_MAX;
            end else begin
                res_dist = div_quo[COORD_W-1:0] - COORD_W'(1);
            end
        end else begin
            if (div_ovf || div_quo[COORD_W:COORD_W-1] != 2'b00) begin
                res_dist = DIST_MIN;
            end else begin
                res_dist = ~div_quo[COORD_W-1:0];
            end
        end
    end

    // output register with skid
    always_comb begin
        out_load        = !out_valid_reg || m_tready;
        out_valid_next  = out_valid_reg;
        out_hit_next    = out_hit_reg;
        out_dist_next   = out_dist_reg;
        skid_valid_next = skid_valid_reg;
        skid_hit_next   = skid_hit_reg;
        skid_dist_next  = skid_dist_reg;
        if (out_load) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_hit_next    = skid_hit_reg;
                out_dist_next   = skid_dist_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_hit_next   = res_hit;
                out_dist_next  = res_dist;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_hit_next   = res_hit;
            skid_dist_next  = res_dist;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_hit_reg   <= out_hit_next;
        out_dist_reg  <= out_dist_next;
        skid_hit_reg  <= skid_hit_next;
        skid_dist_reg <= skid_dist_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_dist_reg;
    assign m_tuser  = out_hit_reg;

endmodule

`default_nettype wire

FILE: rtl/rpi_checker.sv
`default_nettype none

`include "assert_macros.svh"

module rpi_checker #(
    parameter int FRAC_BITS = rpi_pkg::RPI_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rpi_pkg::COORD_W-1:0]   m_tdata,
    input  logic                          m_tuser
);
    import rpi_pkg::*;

    localparam logic [COORD_W-1:0] MISS_DIST = -(COORD_W'(1) << FRAC_BITS);

    logic out_stalled;
    logic in_blocked;

    assign out_stalled = m_tvalid && !m_tready;
    assign in_blocked  = s_tvalid && !s_tready;

    `RPI_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stalled, m_tvalid)
    `RPI_ASSERT_NEXT(a_out_stable, aclk, aresetn, out_stalled, $stable(m_tdata) && $stable(m_tuser))
    `RPI_ASSERT_NOW(a_miss_value, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == MISS_DIST)
    `RPI_ASSERT_NOW(a_block_needs_result, aclk, aresetn, in_blocked, m_tvalid)
    `RPI_ASSERT_NOW(a_block_after_stall, aclk, aresetn, !s_tready, $past(out_stalled))

endmodule

bind ray_plane_intersect rpi_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_rpi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: dv/tb_ray_plane_intersect.sv
`timescale 1ns / 1ps

module tb_ray_plane_intersect;
    import rpi_pkg::*;

    localparam int FRAC = RPI_FRAC_BITS;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES = 50;
    localparam int RANDOM_PHASES = 8;
    localparam int RAYS_PER_PHASE = 66;
    localparam logic signed [COORD_W-1:0] ONE = 1 <<< FRAC;
    localparam logic signed [COORD_W-1:0] C_MAX = DIST_MAX;
    localparam logic signed [COORD_W-1:0] C_MIN = DIST_MIN;
    localparam logic signed [OFFSET_W-1:0] OFF_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};
    localparam logic signed [OFFSET_W-1:0] OFF_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_INDEX = '1;

    // origin_x in the low bits, dir_z in the high bits
    typedef struct packed {
        logic signed [COORD_W-1:0] dir_z, dir_y, dir_x, origin_z, origin_y, origin_x;
    } ray_t;

    typedef struct {
        logic               hit;
        logic [COORD_W-1:0] distance;
    } result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [OFFSET_W-1:0]    cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [COORD_W-1:0]     m_tdata;
    logic                   m_tuser;

    logic signed [COORD_W-1:0]  plane_nx = '0;
    logic signed [COORD_W-1:0]  plane_ny = NORMAL_Y_RESET;
    logic signed [COORD_W-1:0]  plane_nz = '0;
    logic signed [OFFSET_W-1:0] plane_off = '0;

    result_t     pending_hits[$];
    bit          tx_idle;
    bit          rx_idle;
    int          stall_left;
    int unsigned cycle_count = 0;
    int unsigned rays_sent = 0;
    int unsigned words_seen = 0;
    int unsigned hits_seen = 0;
    int unsigned misses_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatch_count = 0;

    ray_plane_intersect i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d words still expected",
                 cycle_count, pending_hits.size());
        $display("end of test: mismatches");
        $finish;
    end

    function automatic result_t plane_hit_of(input ray_t r);
        logic signed [127:0] nx, ny, nz, ox, oy, oz, dx, dy, dz;
        logic signed [127:0] den, num;
        logic [127:0]        dmag, nmag, quo;
        logic signed [63:0]  t;
        result_t             res;
        nx = plane_nx;
        ny = plane_ny;
        nz = plane_nz;
        ox = r.origin_x;
        oy = r.origin_y;
        oz = r.origin_z;
        dx = r.dir_x;
        dy = r.dir_y;
        dz = r.dir_z;
        den = nx * dx + ny * dy + nz * dz;
        dmag = den[127] ? -den : den;
        if (dmag < (128'd1 << FRAC)) begin
            res.hit = 1'b0;
            res.distance = -(32'sd1 <<< FRAC);
            return res;
        end
        num = plane_off;
        num = num <<< FRAC;
        num = num - (nx * ox + ny * oy + nz * oz);
        nmag = num[127] ? -num : num;
        nmag = nmag << FRAC;
        quo = nmag / dmag;
        if (quo > (128'd1 << 32)) begin
            quo = 128'd1 << 32;
        end
        t = (num[127] != den[127]) ? -$signed(quo[63:0]) : $signed(quo[63:0]);
        t = t - 1;
        res.hit = 1'b1;
        if (t > 64'sh7fff_ffff) begin
            res.distance = DIST_MAX;
        end else if (t < -64'sh8000_0000) begin
            res.distance = DIST_MIN;
        end else begin
            res.distance = t[COORD_W-1:0];
        end
        return res;
    endfunction

    function automatic ray_t make_ray(input logic signed [COORD_W-1:0] ox, oy, oz, dx, dy, dz);
        ray_t r;
        r.origin_x = ox;
        r.origin_y = oy;
        r.origin_z = oz;
        r.dir_x = dx;
        r.dir_y = dy;
        r.dir_z = dz;
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] extreme_coord();
        case ($urandom_range(0, 5))
            0: return C_MIN;
            1: return C_MAX;
            2: return 0;
            3: return 1;
            4: return -1;
            default: return ONE;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] moderate_coord();
        return int'($urandom_range(0, 2 ** 22)) - 2 ** 21;
    endfunction

    function automatic ray_t random_ray();
        ray_t r;
        int   wobble;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            end
            3: begin
                r = make_ray(extreme_coord(), extreme_coord(), extreme_coord(),
                             extreme_coord(), extreme_coord(), extreme_coord());
            end
            4, 5: begin
                // direction nearly in the plane
                wobble = int'($urandom_range(0, 4)) - 2;
                r = make_ray(moderate_coord(), moderate_coord(), moderate_coord(),
                             plane_ny + wobble, -plane_nx, 0);
            end
            default: begin
                r = make_ray(moderate_coord(), moderate_coord(), moderate_coord(),
                             moderate_coord(), moderate_coord(), moderate_coord());
            end
        endcase
        return r;
    endfunction

    initial begin
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 16) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (pending_hits.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected word: hit %0b distance %h", m_tuser, m_tdata);
                end
            end else begin
                want = pending_hits.pop_front();
                if (m_tuser !== want.hit || m_tdata !== want.distance) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("word %0d: expected hit %0b distance %h, got hit %0b distance %h",
                                 words_seen, want.hit, want.distance, m_tuser, m_tdata);
                    end
                end
                if (want.hit) begin
                    hits_seen++;
                end else begin
                    misses_seen++;
                end
            end
        end
    end

    task automatic send_ray(input ray_t r);
        int gap;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= r;
        do @(posedge aclk); while (!s_tready);
        pending_hits.push_back(plane_hit_of(r));
        rays_sent++;
    endtask

    task automatic drain_rays();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [OFFSET_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_NORMAL_X: plane_nx = value[COORD_W-1:0];
            REG_NORMAL_Y: plane_ny = value[COORD_W-1:0];
            REG_NORMAL_Z: plane_nz = value[COORD_W-1:0];
            REG_PLANE_OFFSET: plane_off = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_plane(input logic signed [COORD_W-1:0] nx, ny, nz,
                             input logic signed [OFFSET_W-1:0] off);
        drain_rays();
        write_reg(REG_NORMAL_X, OFFSET_W'(nx));
        write_reg(REG_NORMAL_Y, OFFSET_W'(ny));
        write_reg(REG_NORMAL_Z, OFFSET_W'(nz));
        write_reg(REG_PLANE_OFFSET, off);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_INDEX_W'(REG_PLANE_OFFSET) + CFG_INDEX_W'($urandom_range(1, 12)),
                      OFFSET_W'({$urandom, $urandom}));
        end
    endtask

    task automatic test_default_plane();
        send_ray(make_ray(0, 2 * ONE, 0, 0, -ONE, 0));
        send_ray(make_ray(ONE, 5 * ONE, -ONE, ONE, 0, ONE));
        send_ray(make_ray(3 * ONE, 0, 7, 0, ONE, 0));
        send_ray(make_ray(0, -ONE, 0, 0, 1, 0));
        send_ray(make_ray(0, -ONE, 0, 0, -1, 0));
    endtask

    task automatic test_parallel_threshold();
        set_plane(1, 0, 0, 0);
        send_ray(make_ray(-ONE, 0, 0, ONE - 1, 0, 0));
        send_ray(make_ray(-ONE, 0, 0, ONE, 0, 0));
        send_ray(make_ray(-ONE, 0, 0, -ONE, 0, 0));
        send_ray(make_ray(-ONE, 0, 0, -(ONE - 1), 0, 0));
        drain_rays();
        write_reg(REG_LAST_INDEX, '1);
        send_ray(make_ray(2 * ONE, 0, 0, ONE, 0, 0));
    endtask

    task automatic test_field_extremes();
        set_plane(C_MAX, C_MIN, C_MAX, OFF_MAX);
        send_ray(make_ray(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_ray(make_ray(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_ray(make_ray(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
        send_ray(make_ray(C_MAX, C_MIN, C_MAX, 0, 0, 0));
        set_plane(C_MIN, C_MIN, C_MIN, OFF_MIN);
        send_ray(make_ray(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_ray(make_ray(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        send_ray(make_ray(0, 0, 0, 1, 0, 0));
    endtask

    task automatic test_quotient_rounding();
        set_plane(0, 0, ONE, 0);
        send_ray(make_ray(0, 0, -7, 0, 0, 3 * ONE));
        send_ray(make_ray(0, 0, 7, 0, 0, 3 * ONE));
    endtask

    task automatic test_random_planes();
        int axis;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_plane(0, NORMAL_Y_RESET, 0, 0);
                2: set_plane(extreme_coord(), extreme_coord(), extreme_coord(),
                             ($urandom_range(0, 1) == 1) ? OFF_MAX : OFF_MIN);
                3: set_plane(int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4,
                             int'($urandom_range(0, 8)) - 4, moderate_coord());
                4: begin
                    axis = $urandom_range(0, 2);
                    set_plane((axis == 0) ? ONE : 0, (axis == 1) ? -ONE : 0,
                              (axis == 2) ? ONE : 0, moderate_coord());
                end
                default: set_plane($urandom, $urandom, $urandom, OFFSET_W'({$urandom, $urandom}));
            endcase
            // idle-free stretches, including the closing one
            tx_idle = (phase != 5) && (phase != RANDOM_PHASES - 1);
            rx_idle = tx_idle;
            repeat (RAYS_PER_PHASE) send_ray(random_ray());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_plane();
        test_parallel_threshold();
        test_field_extremes();
        test_quotient_rounding();
        test_random_planes();

        drain_rays();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("%0d rays against %0d register writes, default, extreme, tiny and random planes",
                 rays_sent, reg_writes);
        $display("%0d words checked: %0d hits, %0d parallel misses, %0d mismatches",
                 words_seen, hits_seen, misses_seen, mismatch_count);
        if (mismatch_count == 0 && pending_hits.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
